### rtl/vbsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbsd_pkg
// Shared types and constants of the VLIW bundle syllable dispatcher.
// ----------------------------------------------------------------------------
package vbsd_pkg;

    localparam int WORD_W               = 32;
    localparam int MAX_BUNDLE_WORDS_DEF = 8;
    localparam int WPOS_W               = 4;
    localparam logic [WPOS_W-1:0] WPOS_SAT = 4'd15;
    localparam int NSLOTS               = 6;
    localparam int NEXT                 = 4;
    localparam int QDEPTH               = 2;
    localparam int QPTR_W               = $clog2(QDEPTH);
    localparam int OUT_W                = 104;

    localparam logic [2:0] SLOT_BRANCH = 3'd0;
    localparam logic [2:0] SLOT_COPROC = 3'd1;
    localparam logic [2:0] SLOT_ALU0   = 3'd2;
    localparam logic [2:0] SLOT_ALU1   = 3'd3;
    localparam logic [2:0] SLOT_MUL    = 3'd4;
    localparam logic [2:0] SLOT_LSU    = 3'd5;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_COPROC = 3'd1;
    localparam logic [2:0] ST_EXT    = 3'd2;
    localparam logic [2:0] ST_ALU    = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_LSU    = 3'd5;
    localparam logic [2:0] ST_LONG   = 3'd6;

    localparam logic [1:0] STEER_BR  = 2'd0;
    localparam logic [1:0] STEER_LSU = 2'd1;
    localparam logic [1:0] STEER_MUL = 2'd2;
    localparam logic [1:0] STEER_ALU = 2'd3;

    localparam logic [30:0] ALU_NOP = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_SLOT = 2'd1,
        CMD_EXT  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        t_cmd_kind         kind;
        logic [2:0]        slot;
        logic [1:0]        ext_tgt;
        logic              ext_sel;
        logic              last_word;
        logic [2:0]        err;
    } t_cmd;

    function automatic logic is_coproc(input logic [WORD_W-1:0] x);
        return (x[28:27] == 2'd0) && (x[26:24] != 3'd0);
    endfunction

endpackage

### rtl/vbsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbsd_front
// Accepts syllables, tracks slot occupancy and errors, and issues one
// placement command per syllable into the command queue.
// ----------------------------------------------------------------------------
module vbsd_front #(
    parameter int MAX_BUNDLE_WORDS = vbsd_pkg::MAX_BUNDLE_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [vbsd_pkg::WORD_W-1:0] i_syllable,
    input  logic                        i_q_ready,
    output logic                        o_push,
    output vbsd_pkg::t_cmd              o_cmd
);

    localparam logic [vbsd_pkg::WPOS_W:0] MAX_W = (vbsd_pkg::WPOS_W + 1)'(MAX_BUNDLE_WORDS);

    logic [vbsd_pkg::WPOS_W-1:0] r_wp, n_wp;
    logic [vbsd_pkg::NSLOTS-1:0] r_valid, n_valid;
    logic [1:0]                  r_ext_cnt [vbsd_pkg::NEXT];
    logic [1:0]                  n_ext_cnt [vbsd_pkg::NEXT];
    logic [2:0]                  r_err, n_err;

    logic       accept;
    logic       more;
    logic       cop;
    logic [1:0] steer;
    logic [1:0] e;
    logic [2:0] err_new;
    vbsd_pkg::t_cmd cmd;

    assign accept = i_valid && i_q_ready;
    assign more   = i_syllable[31];
    assign cop    = vbsd_pkg::is_coproc(i_syllable);
    assign steer  = i_syllable[30:29];
    assign e      = i_syllable[28:27];

    always_comb begin
        cmd           = '0;
        cmd.word      = i_syllable;
        cmd.kind      = vbsd_pkg::CMD_NONE;
        cmd.ext_tgt   = e;
        cmd.ext_sel   = r_ext_cnt[e][0];
        err_new       = vbsd_pkg::ST_OK;
        if (r_err == vbsd_pkg::ST_OK) begin
            case (steer)
                vbsd_pkg::STEER_BR: begin
                    if (r_wp == '0) begin
                        cmd.kind = vbsd_pkg::CMD_SLOT;
                        cmd.slot = cop ? vbsd_pkg::SLOT_COPROC : vbsd_pkg::SLOT_BRANCH;
                    end else if (r_wp == 4'd1 && r_valid[vbsd_pkg::SLOT_BRANCH] && cop) begin
                        if (r_valid[vbsd_pkg::SLOT_COPROC]) begin
                            err_new = vbsd_pkg::ST_COPROC;
                        end else begin
                            cmd.kind = vbsd_pkg::CMD_SLOT;
                            cmd.slot = vbsd_pkg::SLOT_COPROC;
                        end
                    end else if (r_ext_cnt[e] > 2'd1) begin
                        err_new = vbsd_pkg::ST_EXT;
                    end else begin
                        cmd.kind = vbsd_pkg::CMD_EXT;
                    end
                end
                vbsd_pkg::STEER_ALU: begin
                    cmd.kind = vbsd_pkg::CMD_SLOT;
                    if (!r_valid[vbsd_pkg::SLOT_ALU0]) begin
                        cmd.slot = vbsd_pkg::SLOT_ALU0;
                    end else if (!r_valid[vbsd_pkg::SLOT_ALU1]) begin
                        cmd.slot = vbsd_pkg::SLOT_ALU1;
                    end else if (!r_valid[vbsd_pkg::SLOT_MUL]) begin
                        cmd.slot = vbsd_pkg::SLOT_MUL;
                    end else if (!r_valid[vbsd_pkg::SLOT_LSU]) begin
                        cmd.slot = vbsd_pkg::SLOT_LSU;
                    end else begin
                        cmd.kind = vbsd_pkg::CMD_NONE;
                        if (i_syllable[30:0] != vbsd_pkg::ALU_NOP) begin
                            err_new = vbsd_pkg::ST_ALU;
                        end
                    end
                end
                vbsd_pkg::STEER_MUL: begin
                    if (r_valid[vbsd_pkg::SLOT_MUL]) begin
                        err_new = vbsd_pkg::ST_MUL;
                    end else begin
                        cmd.kind = vbsd_pkg::CMD_SLOT;
                        cmd.slot = vbsd_pkg::SLOT_MUL;
                    end
                end
                default: begin
                    if (r_valid[vbsd_pkg::SLOT_LSU]) begin
                        err_new = vbsd_pkg::ST_LSU;
                    end else begin
                        cmd.kind = vbsd_pkg::CMD_SLOT;
                        cmd.slot = vbsd_pkg::SLOT_LSU;
                    end
                end
            endcase
            if (err_new == vbsd_pkg::ST_OK && more &&
                ({1'b0, r_wp} + 5'd1) >= MAX_W) begin
                err_new = vbsd_pkg::ST_LONG;
            end
            if (err_new != vbsd_pkg::ST_OK) begin
                cmd.kind = vbsd_pkg::CMD_NONE;
            end
        end
        n_err         = (r_err != vbsd_pkg::ST_OK) ? r_err : err_new;
        cmd.err       = n_err;
        cmd.last_word = !more;
    end

    always_comb begin
        n_valid   = r_valid;
        n_ext_cnt = r_ext_cnt;
        n_wp      = (r_wp == vbsd_pkg::WPOS_SAT) ? r_wp : r_wp + 4'd1;
        if (cmd.kind == vbsd_pkg::CMD_SLOT) begin
            n_valid = r_valid | (vbsd_pkg::NSLOTS'(1) << cmd.slot);
        end
        if (cmd.kind == vbsd_pkg::CMD_EXT) begin
            n_ext_cnt[e] = r_ext_cnt[e] + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_valid <= '0;
            r_err   <= vbsd_pkg::ST_OK;
            for (int i = 0; i < vbsd_pkg::NEXT; i++) begin
                r_ext_cnt[i] <= '0;
            end
        end else if (accept) begin
            if (!more) begin
                r_wp    <= '0;
                r_valid <= '0;
                r_err   <= vbsd_pkg::ST_OK;
                for (int i = 0; i < vbsd_pkg::NEXT; i++) begin
                    r_ext_cnt[i] <= '0;
                end
            end else begin
                r_wp      <= n_wp;
                r_valid   <= n_valid;
                r_err     <= n_err;
                r_ext_cnt <= n_ext_cnt;
            end
        end
    end

    assign o_push = accept;
    assign o_cmd  = cmd;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !more |=> r_wp == '0 && r_valid == '0 && r_err == vbsd_pkg::ST_OK)
        else $error("bundle state not cleared at bundle end");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != vbsd_pkg::ST_OK && accept && more |=> r_err == $past(r_err))
        else $error("error code changed inside a bundle");

endmodule

### rtl/vbsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbsd_queue
// Short command queue between the classifier and the slot issue stage.
// ----------------------------------------------------------------------------
module vbsd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vbsd_pkg::t_cmd i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output vbsd_pkg::t_cmd o_cmd
);

    vbsd_pkg::t_cmd                r_mem [vbsd_pkg::QDEPTH];
    logic [vbsd_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [vbsd_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [vbsd_pkg::QPTR_W:0]     r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_ready = r_count != (vbsd_pkg::QPTR_W + 1)'(vbsd_pkg::QDEPTH);
    assign o_valid = r_count != '0;
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (vbsd_pkg::QPTR_W + 1)'(vbsd_pkg::QDEPTH))
        else $error("queue count beyond depth");

endmodule

### rtl/vbsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbsd_back
// Carries out placement commands into slot storage and, at bundle end,
// issues one item per valid slot in slot order, or one error status item.
// ----------------------------------------------------------------------------
module vbsd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  vbsd_pkg::t_cmd              i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [vbsd_pkg::OUT_W-1:0]  o_tdata,
    output logic                        o_tlast
);

    typedef enum logic [1:0] {
        S_FILL = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state                       r_state;
    logic [vbsd_pkg::NSLOTS-1:0]  r_valid;
    logic [vbsd_pkg::NSLOTS-1:0]  r_pend;
    logic [2:0]                   r_err;
    logic [1:0]                   r_cnt  [vbsd_pkg::NEXT];
    logic [vbsd_pkg::WORD_W-1:0]  r_opc  [vbsd_pkg::NSLOTS];
    logic [vbsd_pkg::WORD_W-1:0]  r_ext0 [vbsd_pkg::NEXT];
    logic [vbsd_pkg::WORD_W-1:0]  r_ext1 [vbsd_pkg::NEXT];
    logic                         r_out_valid;
    logic [vbsd_pkg::OUT_W-1:0]   r_out_data;
    logic                         r_out_last;

    logic [vbsd_pkg::NSLOTS-1:0]  cmd_bit;
    logic [vbsd_pkg::NSLOTS-1:0]  pick_bit;
    logic [vbsd_pkg::NSLOTS-1:0]  pend_rem;
    logic [2:0]                   pick;
    logic [2:0]                   tgt_full;
    logic [1:0]                   tgt;
    logic [1:0]                   cnt;
    logic                         out_load;
    logic                         out_last;
    logic [vbsd_pkg::OUT_W-1:0]   out_data;
    logic [vbsd_pkg::WORD_W-1:0]  ext_a;
    logic [vbsd_pkg::WORD_W-1:0]  ext_b;

    assign o_q_pop  = (r_state == S_FILL) && i_q_valid;
    assign cmd_bit  = (i_q_cmd.kind == vbsd_pkg::CMD_SLOT) ?
                      (vbsd_pkg::NSLOTS'(1) << i_q_cmd.slot) : '0;
    assign pick_bit = r_pend & (~r_pend + 1'b1);
    assign pend_rem = r_pend & ~pick_bit;
    assign out_load = (r_state == S_EMIT) && (!r_out_valid || i_tready);

    always_comb begin
        pick = vbsd_pkg::SLOT_BRANCH;
        for (int i = vbsd_pkg::NSLOTS - 1; i >= 0; i--) begin
            if (pick_bit[i]) begin
                pick = 3'(i);
            end
        end
    end

    assign tgt_full = pick - vbsd_pkg::SLOT_ALU0;
    assign tgt      = tgt_full[1:0];

    always_comb begin
        cnt      = (pick >= vbsd_pkg::SLOT_ALU0) ? r_cnt[tgt] : 2'd0;
        ext_a    = (cnt >= 2'd1) ? r_ext0[tgt] : '0;
        ext_b    = (cnt >= 2'd2) ? r_ext1[tgt] : '0;
        out_data = '0;
        out_last = 1'b1;
        if (r_err != vbsd_pkg::ST_OK) begin
            out_data[2:0] = r_err;
        end else if (r_pend != '0) begin
            out_data = {ext_b, ext_a, r_opc[pick], cnt + 2'd1, pick, vbsd_pkg::ST_OK};
            out_last = pend_rem == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_valid     <= '0;
            r_pend      <= '0;
            r_err       <= vbsd_pkg::ST_OK;
            r_out_valid <= 1'b0;
            for (int i = 0; i < vbsd_pkg::NEXT; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            case (r_state)
                S_FILL: begin
                    if (i_q_valid) begin
                        r_valid <= r_valid | cmd_bit;
                        if (i_q_cmd.kind == vbsd_pkg::CMD_EXT) begin
                            r_cnt[i_q_cmd.ext_tgt] <= {1'b0, i_q_cmd.ext_sel} + 2'd1;
                        end
                        if (i_q_cmd.last_word) begin
                            r_err   <= i_q_cmd.err;
                            r_pend  <= r_valid | cmd_bit;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_pend <= pend_rem;
                        if (out_last) begin
                            r_valid <= '0;
                            r_err   <= vbsd_pkg::ST_OK;
                            r_state <= S_FILL;
                            for (int i = 0; i < vbsd_pkg::NEXT; i++) begin
                                r_cnt[i] <= '0;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            if (i_q_cmd.kind == vbsd_pkg::CMD_SLOT) begin
                r_opc[i_q_cmd.slot] <= i_q_cmd.word;
            end
            if (i_q_cmd.kind == vbsd_pkg::CMD_EXT) begin
                if (i_q_cmd.ext_sel) begin
                    r_ext1[i_q_cmd.ext_tgt] <= i_q_cmd.word;
                end else begin
                    r_ext0[i_q_cmd.ext_tgt] <= i_q_cmd.word;
                end
            end
        end
        if (out_load) begin
            r_out_data <= out_data;
            r_out_last <= out_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[2:0] != vbsd_pkg::ST_OK |-> r_out_last)
        else $error("error status item not marked last");

    a_fill_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL && i_q_valid && !i_q_cmd.last_word |=> r_state == S_FILL)
        else $error("issue started before bundle end");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && out_last |=> r_state == S_FILL && r_valid == '0)
        else $error("slot state not cleared after last item");

endmodule

### rtl/vliw_bundle_syllable_dispatch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vliw_bundle_syllable_dispatch
// Gathers instruction syllables into six issue slots and issues the bundle.
// ----------------------------------------------------------------------------
// Throughput: one syllable per cycle while the two-entry command queue has room.
// With the issue stage idle, a bundle's last syllable passes the command queue, the
// emit state and output register; then one result per cycle unless stalled, one per
// valid slot (1 to 6). The issue stage takes no new commands while a bundle drains.
// Reset: synchronous, active low; clears control state, slot storage is not cleared.
module vliw_bundle_syllable_dispatch #(
    parameter int MAX_BUNDLE_WORDS = vbsd_pkg::MAX_BUNDLE_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [vbsd_pkg::WORD_W-1:0] i_s_axis_tdata,  // syllable
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // status, issue_slot, word_count, opcode_word, first_extension, second_extension
    output logic [vbsd_pkg::OUT_W-1:0]  o_m_axis_tdata,
    output logic                        o_m_axis_tlast   // last
);

    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           q_pop;
    vbsd_pkg::t_cmd push_cmd;
    vbsd_pkg::t_cmd head_cmd;

    assign o_s_axis_tready = q_ready;

    vbsd_front #(
        .MAX_BUNDLE_WORDS (MAX_BUNDLE_WORDS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_syllable (i_s_axis_tdata),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    vbsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    vbsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_q_pop   (q_pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tlast   (o_m_axis_tlast)
    );

endmodule
